FILE: rtl/ikeda_map_point_generator_top_macros.svh
// ----------------------------------------------------------------------------
// Ikeda map point generator assertion macros
// Shared assertion wrappers clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef IKEDA_MAP_POINT_GENERATOR_TOP_MACROS_SVH
`define IKEDA_MAP_POINT_GENERATOR_TOP_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define IKM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ikm assertion failed");

// The condition must never be true outside reset.
`define IKM_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("ikm forbidden condition seen");

`endif

FILE: rtl/ikm_pkg.sv
// ----------------------------------------------------------------------------
// Ikeda map package
// Shared types, fixed constants and helper functions of the map generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ikm_pkg;

  // Operand width of the shared multiplier and its product width.
  localparam int unsigned MUL_W  = 35;
  localparam int unsigned PROD_W = 2 * MUL_W;
  // Width of CORDIC vector components and of angles with 30 fraction bits.
  localparam int unsigned COR_W  = 34;
  localparam int unsigned ANG_W  = 36;
  // Width of the divider quotient register.
  localparam int unsigned QUO_W  = 32;

  localparam logic signed [ANG_W-1:0] PI_30      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] TWO_PI_30  = 36'sd6746518852;
  localparam logic signed [ANG_W-1:0] HALF_PI_30 = 36'sd1686629713;
  localparam logic signed [COR_W-1:0] GAIN_30    = 34'sd652032874;

  // Reciprocal of ten; a product shifted down by RECIP_SHIFT gives the exact
  // floor of a division by ten for any value below 2^32.
  localparam logic signed [MUL_W-1:0] RECIP10     = 35'sd3435973837;
  localparam int unsigned             RECIP_SHIFT = 35;

  // Arctangent of 2^-i with 30 fraction bits, truncated.
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
    32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
    32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
    32'd262143,    32'd131071,    32'd65535,     32'd32767,
    32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127,
    32'd63,        32'd31,        32'd15,        32'd7,
    32'd3,         32'd1,         32'd0,         32'd0
  };

  // Configuration register indexes.
  typedef enum logic {
    REG_COEFF_A = 1'b0,
    REG_COEFF_B = 1'b1
  } ikm_reg_e;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_DIV,
    ST_ANG,
    ST_COR,
    ST_R0,
    ST_R1,
    ST_R2,
    ST_R3,
    ST_R4,
    ST_R5,
    ST_R6,
    ST_R7,
    ST_NX,
    ST_NY,
    ST_OUT
  } ikm_state_e;

  // Start request for the divider.
  typedef struct packed {
    logic       start;
    logic [4:0] nbits;
  } ikm_div_ctrl_t;

  // Status reported by an iterative unit.
  typedef struct packed {
    logic busy;
    logic done;
  } ikm_unit_sts_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic [31:0] r;
    if (v > $signed(PROD_W'(32'sh7fff_ffff))) begin
      r = 32'h7fff_ffff;
    end else if (v < -$signed(PROD_W'(64'h8000_0000))) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ikm_mul.sv
// ----------------------------------------------------------------------------
// Ikeda map shared multiplier
// Signed multiplier with a registered product, loaded when enabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ikm_mul (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [ikm_pkg::MUL_W-1:0]    a_i,
  input  wire logic signed [ikm_pkg::MUL_W-1:0]    b_i,
  output logic signed      [ikm_pkg::PROD_W-1:0]   prod_o
);
  import ikm_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  // The product holds until the next enabled cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: rtl/ikm_div.sv
// ----------------------------------------------------------------------------
// Ikeda map iterative divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ikm_div #(
  parameter int unsigned DEN_W = 40
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ikm_pkg::ikm_div_ctrl_t        ctrl_i,
  input  wire logic [63:0]                   dividend_i,
  input  wire logic [DEN_W-1:0]              divisor_i,
  output ikm_pkg::ikm_unit_sts_t             sts_o,
  output logic [ikm_pkg::QUO_W-1:0]          quo_o
);
  import ikm_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [63:0]      low_q, low_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   trial;
  logic             ge;

  // One trial subtraction per cycle; the next dividend bit enters at the bottom.
  always_comb begin
    trial  = {rem_q, low_q[63]};
    ge     = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    low_d  = low_q;
    quo_d  = quo_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = ctrl_i.nbits;
      rem_d  = DEN_W'(dividend_i >> ctrl_i.nbits);
      low_d  = dividend_i << (7'd64 - {2'b0, ctrl_i.nbits});
      den_d  = divisor_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      low_d = {low_q[62:0], 1'b0};
      quo_d = {quo_q[QUO_W-2:0], ge};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    low_q <= low_d;
    quo_q <= quo_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = quo_q;

endmodule

`default_nettype wire

FILE: rtl/ikm_cordic.sv
// ----------------------------------------------------------------------------
// Ikeda map CORDIC unit
// Reduces an angle to the CORDIC range and rotates one step per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ikm_cordic #(
  parameter int unsigned ITERS = 20
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic signed [ikm_pkg::ANG_W-1:0]   angle_i,
  output ikm_pkg::ikm_unit_sts_t                  sts_o,
  output logic signed      [ikm_pkg::COR_W-1:0]   cos_o,
  output logic signed      [ikm_pkg::COR_W-1:0]   sin_o
);
  import ikm_pkg::*;

  localparam int unsigned CNT_W = $clog2(ITERS);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    neg_q, neg_d;
  logic signed [COR_W-1:0] x_q, x_d;
  logic signed [COR_W-1:0] y_q, y_d;
  logic signed [ANG_W-1:0] z_q, z_d;
  logic signed [ANG_W-1:0] wrap;
  logic signed [ANG_W-1:0] atan_step;

  // Angle reduction on start, then one micro-rotation per cycle.
  always_comb begin
    wrap      = (angle_i < -PI_30) ? angle_i + TWO_PI_30 : angle_i;
    atan_step = $signed({4'b0, ATAN_Q30[5'(cnt_q)]});
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    neg_d     = neg_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = GAIN_30;
      y_d    = '0;
      if (wrap > HALF_PI_30) begin
        z_d   = wrap - PI_30;
        neg_d = 1'b1;
      end else if (wrap < -HALF_PI_30) begin
        z_d   = wrap + PI_30;
        neg_d = 1'b1;
      end else begin
        z_d   = wrap;
        neg_d = 1'b0;
      end
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_d = x_q - (y_q >>> cnt_q);
        y_d = y_q + (x_q >>> cnt_q);
        z_d = z_q - atan_step;
      end else begin
        x_d = x_q + (y_q >>> cnt_q);
        y_d = y_q - (x_q >>> cnt_q);
        z_d = z_q + atan_step;
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(ITERS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign cos_o      = neg_q ? -x_q : x_q;
  assign sin_o      = neg_q ? -y_q : y_q;

endmodule

`default_nettype wire

FILE: rtl/ikeda_map_point_generator_top.sv
// ----------------------------------------------------------------------------
// Ikeda map point generator
// Steps an Ikeda-style map once per input transfer and emits the new point.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        sink       in_valid_i/in_stall_o  restart_i
//  out       source     out_valid_o/out_stall_i point_x_o, point_y_o
//  cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// The time from one input transfer to the next is set by the bit-serial
// angle divider (FRAC_BITS + 3 quotient bits) and by the CORDIC iterations.
// The input is stalled for the whole step.
// Reset puts the state at 0.1 and both gains at 0.9; nothing needs clearing.
// A stalled output keeps its point; the next step runs up to its hand-over.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ikeda_map_point_generator_top #(
  parameter int unsigned FRAC_BITS    = 24,
  parameter int unsigned CORDIC_ITERS = 20,
  parameter int unsigned OUT_BITS     = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                restart_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [OUT_BITS-1:0]      point_x_o,
  output logic [OUT_BITS-1:0]      point_y_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_index_i,
  input  wire logic [31:0]         cfg_data_i
);
  import ikm_pkg::*;

  localparam int unsigned DEN_W = 64 - FRAC_BITS;
  localparam logic [63:0] ONE_Q     = 64'd1 << FRAC_BITS;
  localparam logic [63:0] TENTH_Q   = (ONE_Q + 64'd5) / 64'd10;
  localparam logic [63:0] FOURT_Q   = ((ONE_Q << 1) + 64'd2) / 64'd5;
  localparam logic [63:0] NINET_Q   = (64'd9 * ONE_Q + 64'd5) / 64'd10;
  localparam logic [63:0] SPAN_Q    = 64'd10 * ONE_Q;
  localparam logic [63:0] DIV6      = 64'd6 << (2 * FRAC_BITS);
  localparam logic [63:0] OUT_MAX   = (64'd1 << OUT_BITS) - 64'd1;
  localparam logic [4:0]  ANG_BITS  = 5'(FRAC_BITS + 3);

  ikm_state_e state_q, state_d;

  logic [31:0]              coeff_a_q, coeff_b_q;
  logic [31:0]              map_x_q, map_x_d;
  logic [31:0]              map_y_q, map_y_d;
  logic signed [PROD_W-1:0] acc_q, acc_d;
  logic signed [MUL_W-1:0]  rx_q, rx_d;
  logic signed [MUL_W-1:0]  ry_q, ry_d;
  logic [OUT_BITS-1:0]      px_q, px_d;
  logic [OUT_BITS-1:0]      pt_x_q, pt_x_d;
  logic [OUT_BITS-1:0]      pt_y_q, pt_y_d;
  logic                     out_valid_q, out_valid_d;

  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  ikm_div_ctrl_t            div_ctrl;
  logic [63:0]              div_dvd;
  logic [DEN_W-1:0]         div_den;
  ikm_unit_sts_t            div_sts;
  logic [QUO_W-1:0]         quo;
  logic                     cor_start;
  logic signed [ANG_W-1:0]  angle;
  ikm_unit_sts_t            cor_sts;
  logic signed [COR_W-1:0]  cos_v, sin_v;

  logic [63:0]              sq;
  logic signed [PROD_W-1:0] diff;
  logic signed [PROD_W-1:0] summ;
  logic signed [MUL_W-1:0]  vx, vy;
  logic [OUT_BITS-1:0]      norm;
  logic signed [MUL_W-1:0]  vcur;
  logic                     in_xfer;

  ikm_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  ikm_div #(
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (div_dvd),
    .divisor_i  (div_den),
    .sts_o      (div_sts),
    .quo_o      (quo)
  );

  ikm_cordic #(
    .ITERS (CORDIC_ITERS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (angle),
    .sts_o   (cor_sts),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  // Handshake outputs.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign point_x_o   = pt_x_q;
  assign point_y_o   = pt_y_q;

  // Datapath values that feed the sequencer.
  always_comb begin
    sq    = acc_q[63:0] + prod[63:0];
    diff  = (acc_q - prod) >>> 30;
    summ  = (acc_q + prod) >>> 30;
    angle = ($signed({4'b0, FOURT_Q[31:0]}) - $signed({4'b0, quo}))
            <<< (30 - FRAC_BITS);
    vx    = MUL_W'($signed(map_x_q)) + $signed(MUL_W'(5 * ONE_Q));
    vy    = MUL_W'($signed(map_y_q)) + $signed(MUL_W'(5 * ONE_Q));
    vcur  = (state_q == ST_NY) ? vx : vy;
    // The product holds the scaled coordinate times the reciprocal of ten.
    if (vcur <= 0) begin
      norm = '0;
    end else if (vcur >= $signed(MUL_W'(SPAN_Q))) begin
      norm = OUT_MAX[OUT_BITS-1:0];
    end else begin
      norm = prod[RECIP_SHIFT +: OUT_BITS];
    end
  end

  // Sequencer: next state, unit controls and datapath updates.
  always_comb begin
    state_d        = state_q;
    map_x_d        = map_x_q;
    map_y_d        = map_y_q;
    acc_d          = acc_q;
    rx_d           = rx_q;
    ry_d           = ry_q;
    px_d           = px_q;
    pt_x_d         = pt_x_q;
    pt_y_d         = pt_y_q;
    out_valid_d    = out_valid_q && out_stall_i;
    mul_en         = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    div_ctrl.start = 1'b0;
    div_ctrl.nbits = ANG_BITS;
    div_dvd        = DIV6;
    div_den        = DEN_W'(ONE_Q + (sq >> FRAC_BITS));
    cor_start      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (restart_i) begin
            map_x_d = TENTH_Q[31:0];
            map_y_d = TENTH_Q[31:0];
          end
          state_d = ST_SQ0;
        end
      end
      ST_SQ0: begin
        mul_en  = 1'b1;
        mul_a   = $signed(map_x_q[31] ? -MUL_W'($signed(map_x_q))
                                      : MUL_W'($signed(map_x_q)));
        mul_b   = mul_a;
        state_d = ST_SQ1;
      end
      ST_SQ1: begin
        mul_en  = 1'b1;
        mul_a   = $signed(map_y_q[31] ? -MUL_W'($signed(map_y_q))
                                      : MUL_W'($signed(map_y_q)));
        mul_b   = mul_a;
        acc_d   = prod;
        state_d = ST_SQ2;
      end
      ST_SQ2: begin
        div_ctrl.start = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        if (div_sts.done) begin
          state_d = ST_ANG;
        end
      end
      ST_ANG: begin
        cor_start = 1'b1;
        state_d   = ST_COR;
      end
      ST_COR: begin
        if (cor_sts.done) begin
          state_d = ST_R0;
        end
      end
      ST_R0: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'($signed(map_x_q));
        mul_b   = MUL_W'(cos_v);
        state_d = ST_R1;
      end
      ST_R1: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'($signed(map_y_q));
        mul_b   = MUL_W'(sin_v);
        acc_d   = prod;
        state_d = ST_R2;
      end
      ST_R2: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'($signed(map_x_q));
        mul_b   = MUL_W'(sin_v);
        rx_d    = diff[MUL_W-1:0];
        state_d = ST_R3;
      end
      ST_R3: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'($signed(map_y_q));
        mul_b   = MUL_W'(cos_v);
        acc_d   = prod;
        state_d = ST_R4;
      end
      ST_R4: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'($signed(coeff_a_q));
        mul_b   = rx_q;
        ry_d    = summ[MUL_W-1:0];
        state_d = ST_R5;
      end
      ST_R5: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'($signed(coeff_b_q));
        mul_b   = ry_q;
        map_x_d = sat32((prod >>> FRAC_BITS) + $signed(PROD_W'(ONE_Q)));
        state_d = ST_R6;
      end
      ST_R6: begin
        mul_en  = 1'b1;
        mul_a   = vx;
        mul_b   = MUL_W'(OUT_MAX);
        map_y_d = sat32(prod >>> FRAC_BITS);
        state_d = ST_R7;
      end
      ST_R7: begin
        // Scaled x drops its fraction bits while the y scaling is formed.
        mul_en  = 1'b1;
        mul_a   = vy;
        mul_b   = MUL_W'(OUT_MAX);
        rx_d    = MUL_W'(prod >>> FRAC_BITS);
        state_d = ST_NX;
      end
      ST_NX: begin
        // Divide the scaled x by ten through the reciprocal.
        mul_en  = 1'b1;
        mul_a   = rx_q;
        mul_b   = RECIP10;
        ry_d    = MUL_W'(prod >>> FRAC_BITS);
        state_d = ST_NY;
      end
      ST_NY: begin
        mul_en  = 1'b1;
        mul_a   = ry_q;
        mul_b   = RECIP10;
        px_d    = norm;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // Hand the point over once the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          pt_x_d      = px_q;
          pt_y_d      = norm;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      map_x_q     <= TENTH_Q[31:0];
      map_y_q     <= TENTH_Q[31:0];
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      map_x_q     <= map_x_d;
      map_y_q     <= map_y_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_a_q <= NINET_Q[31:0];
      coeff_b_q <= NINET_Q[31:0];
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ikm_reg_e'(cfg_index_i))
        REG_COEFF_A: coeff_a_q <= cfg_data_i;
        REG_COEFF_B: coeff_b_q <= cfg_data_i;
        default:     coeff_a_q <= coeff_a_q;
      endcase
    end
  end

  // Datapath registers; the output point holds while the output stalls.
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    px_q   <= px_d;
    pt_x_q <= pt_x_d;
    pt_y_q <= pt_y_d;
  end

`include "ikeda_map_point_generator_top_macros.svh"

  // An accepted item keeps the input stalled in the next cycle.
  `IKM_ASSERT(a_busy_after_accept, in_xfer |=> in_stall_o)
  // The divider and the CORDIC unit never run at the same time.
  `IKM_ASSERT_NEVER(a_units_exclusive, div_sts.busy && cor_sts.busy)
  // A new result appears only from the hand-over state.
  `IKM_ASSERT(a_out_from_handover, $rose(out_valid_o) |-> $past(state_q == ST_OUT))

endmodule

`default_nettype wire

FILE: dv/ikm_point_checker.sv
// ----------------------------------------------------------------------------
// Ikeda map point checker
// Watches the input, output and configuration channels of the point
// generator, predicts each point in fixed point and compares it field by
// field with the point that the block emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ikm_point_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic        restart_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [15:0] point_x_i,
  input  wire logic [15:0] point_y_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output int               fail_count_o,
  output int               points_due_o
);
  import ikm_pkg::*;

  localparam longint OneQ     = longint'(1) << 24;
  localparam longint TenthQ   = (OneQ + 5) / 10;
  localparam longint FourTenQ = ((OneQ << 1) + 2) / 5;
  localparam longint NineTenQ = (9 * OneQ + 5) / 10;
  localparam longint PointMax = 65535;

  typedef struct {
    logic [15:0] px;
    logic [15:0] py;
  } map_point_t;

  int         gain_x;
  int         gain_y;
  int         orbit_x;
  int         orbit_y;
  map_point_t points_due[$];

  // Saturate to the signed 32-bit range.
  function automatic int clip32(input logic signed [127:0] v);
    if (v > 128'sh7fff_ffff) return 32'sh7fff_ffff;
    if (v < -128'sh8000_0000) return 32'sh8000_0000;
    return int'(v[31:0]);
  endfunction

  // Map a state coordinate from [-5,5] onto an unsigned fraction.
  function automatic logic [15:0] to_fraction(input int p);
    longint v;
    v = longint'(p) + 5 * OneQ;
    if (v <= 0) return 16'd0;
    if (v >= 10 * OneQ) return 16'hffff;
    return 16'((v * PointMax) / (10 * OneQ));
  endfunction

  // One map step: advances the orbit and returns the emitted point.
  function automatic map_point_t advance_orbit(input logic rs);
    longint            x, y, t, z, cx, cy, dx, dy, rx, ry;
    logic [63:0]       ax, ay, sq, den, quo;
    logic              flip;
    logic signed [127:0] nx, ny;
    map_point_t        pt;
    if (rs) begin
      orbit_x = int'(TenthQ);
      orbit_y = int'(TenthQ);
    end
    x = orbit_x;
    y = orbit_y;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    sq = ax * ax + ay * ay;
    den = 64'(OneQ) + (sq >> 24);
    quo = (64'd6 << 48) / den;
    t = (FourTenQ - longint'(quo)) * 64;
    if (t < -longint'(PI_30)) t = t + longint'(TWO_PI_30);
    // Fold the angle into the CORDIC range.
    flip = 1'b0;
    if (t > longint'(HALF_PI_30)) begin
      t = t - longint'(PI_30);
      flip = 1'b1;
    end else if (t < -longint'(HALF_PI_30)) begin
      t = t + longint'(PI_30);
      flip = 1'b1;
    end
    cx = longint'(GAIN_30);
    cy = 0;
    z = t;
    for (int i = 0; i < 20; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        z = z - longint'(ATAN_Q30[i]);
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        z = z + longint'(ATAN_Q30[i]);
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    rx = (x * cx - y * cy) >>> 30;
    ry = (x * cy + y * cx) >>> 30;
    nx = 128'(OneQ) + ((longint'(gain_x) * 128'(rx)) >>> 24);
    ny = (longint'(gain_y) * 128'(ry)) >>> 24;
    orbit_x = clip32(nx);
    orbit_y = clip32(ny);
    pt.px = to_fraction(orbit_x);
    pt.py = to_fraction(orbit_y);
    return pt;
  endfunction

  // Track register writes, predict on input transfers, check output transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    map_point_t want;
    if (!rst_ni) begin
      gain_x = int'(NineTenQ);
      gain_y = int'(NineTenQ);
      orbit_x = int'(TenthQ);
      orbit_y = int'(TenthQ);
      points_due.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (ikm_reg_e'(cfg_index_i))
          REG_COEFF_A: gain_x = int'(cfg_data_i);
          REG_COEFF_B: gain_y = int'(cfg_data_i);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) points_due = {points_due, advance_orbit(restart_i)};
      if (out_valid_i && !out_stall_i) begin
        if (points_due.size() == 0) begin
          $error("unexpected point transfer x=%0d y=%0d", point_x_i, point_y_i);
          fail_count_o++;
        end else begin
          want = points_due.pop_front();
          if (point_x_i !== want.px) begin
            $error("point_x expected %0d actual %0d", want.px, point_x_i);
            fail_count_o++;
          end
          if (point_y_i !== want.py) begin
            $error("point_y expected %0d actual %0d", want.py, point_y_i);
            fail_count_o++;
          end
        end
      end
    end
    points_due_o = points_due.size();
  end

endmodule

`default_nettype wire

FILE: dv/tb_ikeda_map_point_generator_top.sv
// ----------------------------------------------------------------------------
// Ikeda map point generator testbench
// Drives map steps and register writes into the generator under random
// sender gaps and receiver stalls; a checker beside the block predicts and
// compares every point, and this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_ikeda_map_point_generator_top;
  import ikm_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles  = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        restart_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] point_x_o;
  logic [15:0] point_y_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  int fail_count;
  int points_due;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 1'b0;
  int idle_cycles = 0;

  ikeda_map_point_generator_top dut (.*);

  ikm_point_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .restart_i,
    .out_valid_i(out_valid_o), .out_stall_i, .point_x_i(point_x_o),
    .point_y_i(point_y_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .points_due_o(points_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stalls at random, or solidly during a hold-off.
  always @(posedge clk_i) begin
    out_stall_i <= recv_hold || ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL ikeda_map_point_generator_top");
        $finish;
      end
    end
  end

  // Offer one map step and wait for its transfer.
  task automatic send_step(input logic rs);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i <= rs;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Wait until every point has come out and the block has gone quiet.
  task automatic drain_points();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (points_due != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write; only issued while the block is idle.
  task automatic write_gain(input ikm_reg_e idx, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] gains_a [6];
    logic [31:0] gains_b [6];
    gains_a = '{32'd15099494, 32'h7fff_ffff, 32'h8000_0000, 32'd0,
                $urandom(), 32'd15099494};
    gains_b = '{32'd15099494, 32'h8000_0000, 32'h7fff_ffff, 32'd0,
                $urandom(), 32'd15099494};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: restart and continue from the reset state, then both
    // restart values repeatedly so the orbit wanders.
    send_step(1'b0);
    send_step(1'b1);
    repeat (8) send_step(1'b0);
    send_step(1'b1);
    send_step(1'b1);
    repeat (4) send_step(1'b0);
    drain_points();

    for (int ph = 0; ph < 6; ph++) begin
      write_gain(REG_COEFF_A, gains_a[ph]);
      write_gain(REG_COEFF_B, gains_b[ph]);
      if (ph < 2) begin
        send_gap_pct = 22;
        recv_stall_pct = 71;
      end else if (ph < 4) begin
        send_gap_pct = 71;
        recv_stall_pct = 22;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      // The receiver holds off for a long stretch while steps keep coming.
      if (ph == 1) begin
        fork
          begin
            recv_hold = 1'b1;
            repeat (400) @(posedge clk_i);
            recv_hold = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 105; n++) begin
        send_step($urandom_range(9) == 0);
        // The sender pauses until every point is out.
        if (n == 50) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (points_due != 0) @(posedge clk_i);
        end
      end
      drain_points();
    end

    if (fail_count == 0) begin
      $display("PASS ikeda_map_point_generator_top");
    end else begin
      $display("FAIL ikeda_map_point_generator_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
